[src/srd_pkg.sv]
// shared types, codes and constants of the sprite row run-length decoder
// no dependencies

package srd_pkg;

   localparam int MAX_DIM   = 1024;
   localparam int RUN_BITS  = 6;
   localparam int REG_BITS  = 10;
   localparam int COL_BITS  = 11;
   localparam int ADDR_BITS = 20;
   localparam int DIM_BITS  = 17;
   localparam int IDX_BITS  = 3;

   localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_EXCESS = 3'd1,
      ST_SHORT  = 3'd2,
      ST_PAST   = 3'd3,
      ST_BAD    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_LIT      = 2'd0,
      MODE_REP      = 2'd1,
      MODE_SKIP     = 2'd2,
      MODE_SKIP_END = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_CTRL = 2'd0,
      PH_LIT  = 2'd1,
      PH_REP  = 2'd2
   } phase_type;

   localparam logic [IDX_BITS-1:0] REG_CANVAS_WIDTH   = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH    = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT   = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_FRAME_OFFSET_X = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_FRAME_OFFSET_Y = 3'd4;

   localparam logic [REG_BITS-1:0] CANVAS_WIDTH_RESET = 10'd64;

   typedef struct packed {
      logic latch;   // capture the input beat
      logic mul;     // row times stride
      logic base;    // finish row base, clear row state
      logic step;    // decode step, at most one result
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic more;
   } sts_type;

endpackage

[src/sprite_row_rle_decoder_top.sv]
// top level of the sprite row run-length decoder
// depends on srd_pkg, srd_ctrl and srd_datapath

// Takes one encoded byte per request beat and returns its pixel writes and
// flags as response beats, one at a time, the final one marked by last.
// Each result takes one decode step and then one response beat, which
// the response side may stall; a byte that yields no result takes a
// single decode step and returns no beat. A byte flagged as a row start
// first gets its row base (stride multiply, then offset add). Input is
// held off while the results of a byte are being delivered.
// Configuration writes are registered and are meant for when the block
// is idle. No clearing pass after reset.
module sprite_row_rle_decoder_top #(
   parameter int MAX_DIM = srd_pkg::MAX_DIM
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic [srd_pkg::REG_BITS-1:0]  req_row_index,
   input  logic                          req_row_start,
   input  logic                          req_row_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srd_pkg::ADDR_BITS-1:0] rsp_pixel_address,
   output logic [7:0]                    rsp_pixel_value,
   output logic                          rsp_write_valid,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [srd_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [srd_pkg::REG_BITS-1:0]  csr_wr_data
);

   srd_pkg::cmd_type cmd;
   srd_pkg::sts_type sts;

   srd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_row_start (req_row_start),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   srd_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_data_byte     (req_data_byte),
      .req_row_index     (req_row_index),
      .req_row_end       (req_row_end),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

[src/srd_ctrl.sv]
// controller state machine of the sprite row run-length decoder
// depends on srd_pkg

module srd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_row_start,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  srd_pkg::sts_type sts,
   output srd_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_BASE = 5'b00100,
      S_STEP = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = req_row_start ? S_MUL : S_STEP;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_BASE;
         end
         S_BASE: begin
            cmd.base = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = sts.has_result ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = sts.more ? S_STEP : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/srd_datapath.sv]
// datapath of the sprite row run-length decoder: registers, row state,
// address arithmetic and the result register; depends on srd_pkg

module srd_datapath #(
   parameter int MAX_DIM = srd_pkg::MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srd_pkg::cmd_type                cmd,
   output srd_pkg::sts_type                sts,
   input  logic                            csr_wr_en,
   input  logic [srd_pkg::IDX_BITS-1:0]    csr_index,
   input  logic [srd_pkg::REG_BITS-1:0]    csr_wr_data,
   input  logic [7:0]                      req_data_byte,
   input  logic [srd_pkg::REG_BITS-1:0]    req_row_index,
   input  logic                            req_row_end,
   output logic [srd_pkg::ADDR_BITS-1:0]   rsp_pixel_address,
   output logic [7:0]                      rsp_pixel_value,
   output logic                            rsp_write_valid,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_last
);

   localparam int CB = srd_pkg::COL_BITS;
   localparam int RB = srd_pkg::REG_BITS;
   localparam int AB = srd_pkg::ADDR_BITS;
   localparam int NB = srd_pkg::RUN_BITS;

   // configuration
   logic [RB-1:0] canvas_width_ff, frame_width_ff, frame_height_ff;
   logic [RB-1:0] org_x_ff, org_y_ff;

   // captured beat
   logic [7:0]    byte_ff;
   logic [RB-1:0] row_ff;
   logic          end_ff;

   // row state
   logic [CB-1:0]      column_ff, column_in;
   srd_pkg::phase_type phase_ff, phase_in;
   logic [NB-1:0]      run_ff, run_in;
   logic [AB-1:0]      row_base_ff;
   logic               row_bad_ff;
   logic               append_ff, append_in;
   logic [RB+RB:0]     prod_ff;

   // result register
   logic [AB-1:0] addr_ff;
   logic [7:0]    value_ff;
   logic          wr_ff;
   logic [2:0]    status_ff;
   logic          last_ff;

   logic               res_has;
   logic               res_more;
   logic               res_wr;
   srd_pkg::status_type res_st;
   srd_pkg::mode_type  mode;
   logic [NB-1:0]      len;
   logic [CB-1:0]      fw_col, col_inc, skip_col;
   logic [CB:0]        skip_sum;
   logic               col_lt_fw;
   logic [RB:0]        row_sum;
   logic [RB+RB:0]     base_sum;
   logic               bad_row;

   assign mode      = srd_pkg::mode_type'(byte_ff[7:6]);
   assign len       = byte_ff[NB-1:0];
   assign fw_col    = {1'b0, frame_width_ff};
   assign col_lt_fw = column_ff < fw_col;
   assign col_inc   = (column_ff == srd_pkg::COL_MAX) ? column_ff : column_ff + 1'b1;
   assign skip_sum  = {1'b0, column_ff} + {{(CB+1-NB){1'b0}}, len};
   assign row_sum   = {1'b0, org_y_ff} + {1'b0, row_ff};
   assign base_sum  = prod_ff + {{(RB+1){1'b0}}, org_x_ff};
   assign bad_row   = (row_ff >= frame_height_ff)
                      || ({{(srd_pkg::DIM_BITS-RB){1'b0}}, row_ff}
                          >= srd_pkg::DIM_BITS'(MAX_DIM));

   // more beats follow the one on offer
   assign sts = '{has_result: res_has, more: !last_ff};

   always_comb begin
      skip_col = skip_sum[CB] ? srd_pkg::COL_MAX : skip_sum[CB-1:0];
      if (mode == srd_pkg::MODE_SKIP_END && skip_col < fw_col) begin
         skip_col = fw_col;
      end
   end

   // at most one result per step, with the row state that follows it
   always_comb begin
      res_has   = 1'b0;
      res_more  = 1'b0;
      res_wr    = 1'b0;
      res_st    = srd_pkg::ST_OK;
      column_in = column_ff;
      phase_in  = phase_ff;
      run_in    = run_ff;
      append_in = 1'b0;
      if (append_ff) begin
         res_has = 1'b1;
         res_st  = srd_pkg::ST_SHORT;
      end else if (row_bad_ff) begin
         res_has = 1'b1;
         res_st  = srd_pkg::ST_BAD;
      end else begin
         unique case (phase_ff)
            srd_pkg::PH_CTRL: begin
               if (!col_lt_fw) begin
                  res_has = 1'b1;
                  res_st  = srd_pkg::ST_EXCESS;
               end else begin
                  unique case (mode)
                     srd_pkg::MODE_LIT: begin
                        if (len != '0) begin
                           phase_in = srd_pkg::PH_LIT;
                           run_in   = len;
                        end
                     end
                     srd_pkg::MODE_REP: begin
                        phase_in = srd_pkg::PH_REP;
                        run_in   = len;
                     end
                     srd_pkg::MODE_SKIP, srd_pkg::MODE_SKIP_END: begin
                        column_in = skip_col;
                     end
                     default: column_in = column_ff;
                  endcase
                  if (end_ff && (column_in < fw_col || phase_in != srd_pkg::PH_CTRL)) begin
                     res_has = 1'b1;
                     res_st  = srd_pkg::ST_SHORT;
                  end
               end
            end
            srd_pkg::PH_LIT: begin
               res_has   = 1'b1;
               res_wr    = col_lt_fw;
               res_st    = col_lt_fw ? srd_pkg::ST_OK : srd_pkg::ST_PAST;
               column_in = col_inc;
               run_in    = run_ff - 1'b1;
               phase_in  = (run_ff == NB'(1)) ? srd_pkg::PH_CTRL : srd_pkg::PH_LIT;
               if (end_ff && (col_inc < fw_col || run_ff != NB'(1))) begin
                  if (col_lt_fw) begin
                     res_st = srd_pkg::ST_SHORT;
                  end else begin
                     // skipped pixel keeps its flag, short row follows on its own
                     res_more  = 1'b1;
                     append_in = 1'b1;
                  end
               end
            end
            srd_pkg::PH_REP: begin
               if (run_ff == '0) begin
                  phase_in = srd_pkg::PH_CTRL;
                  if (end_ff && col_lt_fw) begin
                     res_has = 1'b1;
                     res_st  = srd_pkg::ST_SHORT;
                  end
               end else begin
                  res_has   = 1'b1;
                  res_wr    = col_lt_fw;
                  res_st    = col_lt_fw ? srd_pkg::ST_OK : srd_pkg::ST_PAST;
                  column_in = col_inc;
                  run_in    = run_ff - 1'b1;
                  if (run_ff == NB'(1)) begin
                     phase_in = srd_pkg::PH_CTRL;
                     if (end_ff && col_lt_fw && col_inc < fw_col) begin
                        res_st = srd_pkg::ST_SHORT;
                     end
                  end else begin
                     res_more = 1'b1;
                  end
               end
            end
            default: phase_in = srd_pkg::PH_CTRL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff <= srd_pkg::CANVAS_WIDTH_RESET;
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         org_x_ff        <= '0;
         org_y_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            srd_pkg::REG_CANVAS_WIDTH:   canvas_width_ff <= csr_wr_data;
            srd_pkg::REG_FRAME_WIDTH:    frame_width_ff  <= csr_wr_data;
            srd_pkg::REG_FRAME_HEIGHT:   frame_height_ff <= csr_wr_data;
            srd_pkg::REG_FRAME_OFFSET_X: org_x_ff        <= csr_wr_data;
            srd_pkg::REG_FRAME_OFFSET_Y: org_y_ff        <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         phase_ff    <= srd_pkg::PH_CTRL;
         run_ff      <= '0;
         row_base_ff <= '0;
         row_bad_ff  <= 1'b0;
         append_ff   <= 1'b0;
      end else if (cmd.base) begin
         column_ff   <= '0;
         phase_ff    <= srd_pkg::PH_CTRL;
         run_ff      <= '0;
         row_base_ff <= base_sum[AB-1:0];
         row_bad_ff  <= bad_row;
      end else if (cmd.step) begin
         column_ff <= column_in;
         phase_ff  <= phase_in;
         run_ff    <= run_in;
         append_ff <= append_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= req_data_byte;
         row_ff  <= req_row_index;
         end_ff  <= req_row_end;
      end
      if (cmd.mul) begin
         prod_ff <= {{RB{1'b0}}, row_sum} * {{(RB+1){1'b0}}, canvas_width_ff};
      end
      if (cmd.step && res_has) begin
         addr_ff   <= res_wr ? row_base_ff + {{(AB-CB){1'b0}}, column_ff} : '0;
         value_ff  <= res_wr ? byte_ff : 8'd0;
         wr_ff     <= res_wr;
         status_ff <= res_st;
         last_ff   <= !res_more;
      end
   end

   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_value   = value_ff;
   assign rsp_write_valid   = wr_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

endmodule
